/* rtl/isb_pkg.sv */
package isb_pkg;

	localparam int SCREEN_WIDTH_DEF  = 640;
	localparam int SCREEN_HEIGHT_DEF = 480;
	localparam int ICON_EDGE_DEF     = 32;

	localparam int REQ_W      = 2;
	localparam int TICK_W     = 64;
	localparam int CMD_W      = 2;
	localparam int POS_X_W    = 10;
	localparam int POS_Y_W    = 9;
	localparam int COLOR_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CALC_W     = 16;

	localparam logic [REQ_W-1:0] REQ_POLL     = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ACTIVITY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_WAKE     = 2'd2;

	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_WAKE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ICON_COLOR   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RESTORE_EN   = 2'd3;

	localparam int                  START_POS = 100;
	localparam logic signed [CALC_W-1:0] STEP_SIZE = 16'sd2;
	localparam logic [COLOR_W-1:0]  WHITE     = 16'hFFFF;
	localparam logic [COLOR_W-1:0]  BLACK     = 16'h0000;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [TICK_W-1:0] now_ticks;
	} isb_item_t;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [POS_X_W-1:0] pos_x;
		logic [POS_Y_W-1:0] pos_y;
		logic [COLOR_W-1:0] draw_color;
		logic               woke;
		logic               restore_request;
		logic               saver_active;
		logic               last;
	} isb_result_t;

	typedef struct packed {
		logic signed [CALC_W-1:0] pos;
		logic                     neg;
	} isb_axis_t;

endpackage

/* rtl/isb_in_if.sv */
interface isb_in_if;
	import isb_pkg::*;
	logic              valid;
	logic              ready;
	logic [REQ_W-1:0]  req_type;
	logic [TICK_W-1:0] now_ticks;

	modport source (output valid, output req_type, output now_ticks, input ready);
	modport sink (input valid, input req_type, input now_ticks, output ready);
endinterface

/* rtl/isb_out_if.sv */
interface isb_out_if;
	import isb_pkg::*;
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [POS_X_W-1:0] pos_x;
	logic [POS_Y_W-1:0] pos_y;
	logic [COLOR_W-1:0] draw_color;
	logic               woke;
	logic               restore_request;
	logic               saver_active;
	logic               last;

	modport source (output valid, output command, output pos_x, output pos_y,
		output draw_color, output woke, output restore_request, output saver_active,
		output last, input ready);
	modport sink (input valid, input command, input pos_x, input pos_y,
		input draw_color, input woke, input restore_request, input saver_active,
		input last, output ready);
endinterface

/* rtl/idle_screensaver_bounce.sv */
// Idle screensaver with a bouncing icon. Each input transaction is a request
// (poll, activity reset, wake) with the current 64-bit tick count and yields
// zero, one or two result transactions: a wake status on wake, a clear plus a
// white draw at (100,100) when an idle poll times out, and an erase plus a
// draw at the new position on each due frame while active. An item is
// registered on input and evaluated once the two-entry output buffer has room;
// items with no or one result sustain one per cycle while the result port is
// ready, and one with two results holds the next until the single port drains.
// Configuration writes go through cfg_we/cfg_index/cfg_data and are meant to
// happen while the block is idle.
module idle_screensaver_bounce #(
	parameter int SCREEN_WIDTH  = isb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = isb_pkg::SCREEN_HEIGHT_DEF,
	parameter int ICON_EDGE     = isb_pkg::ICON_EDGE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [isb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [isb_pkg::CFG_DATA_W-1:0] cfg_data,
	isb_in_if.sink                         in_ch,
	isb_out_if.source                      out_ch
);
	import isb_pkg::*;

	isb_item_t   item_s1;
	logic        item_v_s1;
	isb_result_t head_q;
	logic        head_v_q;
	isb_result_t pend_q;
	logic        pend_v_q;

	logic        pop;
	logic        fire;
	logic [1:0]  n_res;
	isb_result_t res0;
	isb_result_t res1;

	assign pop  = head_v_q & out_ch.ready;
	assign fire = item_v_s1 & !pend_v_q & (!head_v_q | pop);
	assign in_ch.ready = !item_v_s1 | fire;

	isb_core #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.ICON_EDGE     (ICON_EDGE)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item      (item_s1),
		.n_res     (n_res),
		.res0      (res0),
		.res1      (res1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
			head_v_q  <= 1'b0;
			pend_v_q  <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				item_v_s1 <= 1'b1;
				item_s1   <= '{req_type: in_ch.req_type, now_ticks: in_ch.now_ticks};
			end else if (fire) begin
				item_v_s1 <= 1'b0;
			end

			if (fire) begin
				// fire implies the pend slot is empty and the head is free this cycle
				case (n_res)
					2'd1: begin
						head_q   <= res0;
						head_v_q <= 1'b1;
					end
					2'd2: begin
						head_q   <= res0;
						head_v_q <= 1'b1;
						pend_q   <= res1;
						pend_v_q <= 1'b1;
					end
					default: begin
						if (pop) head_v_q <= 1'b0;
					end
				endcase
			end else if (pop) begin
				head_q   <= pend_q;
				head_v_q <= pend_v_q;
				pend_v_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid           = head_v_q;
	assign out_ch.command         = head_q.command;
	assign out_ch.pos_x           = head_q.pos_x;
	assign out_ch.pos_y           = head_q.pos_y;
	assign out_ch.draw_color      = head_q.draw_color;
	assign out_ch.woke            = head_q.woke;
	assign out_ch.restore_request = head_q.restore_request;
	assign out_ch.saver_active    = head_q.saver_active;
	assign out_ch.last            = head_q.last;

	a_pend_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> head_v_q)
		else $error("pending result without a head result");

	a_pair_buffered: assert property (@(posedge clk) disable iff (!arst_n)
		fire && n_res == 2'd2 |=> pend_v_q && head_v_q && !head_q.last)
		else $error("two-result item not buffered as a pair");

	a_wake_last: assert property (@(posedge clk) disable iff (!arst_n)
		head_v_q && head_q.command == CMD_WAKE |-> head_q.last && !head_q.saver_active)
		else $error("wake status must be the final result with the saver off");

	a_stall_holds_item: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> item_v_s1)
		else $error("input stalled with an empty input stage");

endmodule

/* rtl/isb_core.sv */
module isb_core #(
	parameter int SCREEN_WIDTH  = isb_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = isb_pkg::SCREEN_HEIGHT_DEF,
	parameter int ICON_EDGE     = isb_pkg::ICON_EDGE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [isb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [isb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           fire,
	input  isb_pkg::isb_item_t             item,
	output logic [1:0]                     n_res,
	output isb_pkg::isb_result_t           res0,
	output isb_pkg::isb_result_t           res1
);
	import isb_pkg::*;

	// signed position width with headroom for overshoot before a bounce
	localparam int XW = $clog2(SCREEN_WIDTH + 128) + 1;
	localparam int YW = $clog2(SCREEN_HEIGHT + 128) + 1;

	logic [31:0]        timeout_q;
	logic [31:0]        frame_q;
	logic [COLOR_W-1:0] color_q;
	logic               restore_en_q;

	logic               active_q;
	logic [TICK_W-1:0]  idle_start_q;
	logic [TICK_W-1:0]  last_frame_q;
	logic signed [XW-1:0] icon_x_q;
	logic signed [YW-1:0] icon_y_q;
	logic               step_x_neg_q;
	logic               step_y_neg_q;

	logic               active_d;
	logic [TICK_W-1:0]  idle_start_d;
	logic [TICK_W-1:0]  last_frame_d;
	logic signed [XW-1:0] icon_x_d;
	logic signed [YW-1:0] icon_y_d;
	logic               step_x_neg_d;
	logic               step_y_neg_d;

	logic [TICK_W-1:0]  el_idle;
	logic [TICK_W-1:0]  el_frame;
	logic               idle_due;
	logic               frame_due;
	isb_axis_t          ax;
	isb_axis_t          ay;
	logic signed [CALC_W-1:0] cur_x;
	logic signed [CALC_W-1:0] cur_y;

	function automatic isb_axis_t move_axis(input logic signed [CALC_W-1:0] pos,
		input logic neg, input logic signed [CALC_W-1:0] limit);
		isb_axis_t r;
		logic signed [CALC_W-1:0] p;
		p = neg ? pos - STEP_SIZE : pos + STEP_SIZE;
		r.neg = neg;
		if (p <= 16'sd0 || p + CALC_W'(ICON_EDGE) >= limit) begin
			r.neg = !neg;
			p = r.neg ? p - STEP_SIZE : p + STEP_SIZE;
		end
		r.pos = p;
		return r;
	endfunction

	function automatic isb_result_t mk(input logic [CMD_W-1:0] cmd,
		input logic signed [CALC_W-1:0] x, input logic signed [CALC_W-1:0] y,
		input logic [COLOR_W-1:0] color, input logic wk, input logic rr,
		input logic act, input logic lst);
		isb_result_t r;
		r.command         = cmd;
		r.pos_x           = x[POS_X_W-1:0];
		r.pos_y           = y[POS_Y_W-1:0];
		r.draw_color      = color;
		r.woke            = wk;
		r.restore_request = rr;
		r.saver_active    = act;
		r.last            = lst;
		return r;
	endfunction

	assign el_idle   = item.now_ticks - idle_start_q;
	assign el_frame  = item.now_ticks - last_frame_q;
	assign idle_due  = el_idle >= {32'd0, timeout_q};
	assign frame_due = el_frame >= {32'd0, frame_q};
	assign cur_x     = CALC_W'(icon_x_q);
	assign cur_y     = CALC_W'(icon_y_q);
	assign ax = move_axis(cur_x, step_x_neg_q, CALC_W'(SCREEN_WIDTH));
	assign ay = move_axis(cur_y, step_y_neg_q, CALC_W'(SCREEN_HEIGHT));

	always_comb begin
		n_res        = 2'd0;
		res0         = '0;
		res1         = '0;
		active_d     = active_q;
		idle_start_d = idle_start_q;
		last_frame_d = last_frame_q;
		icon_x_d     = icon_x_q;
		icon_y_d     = icon_y_q;
		step_x_neg_d = step_x_neg_q;
		step_y_neg_d = step_y_neg_q;
		case (item.req_type)
			REQ_ACTIVITY: begin
				active_d     = 1'b0;
				idle_start_d = item.now_ticks;
			end
			REQ_WAKE: begin
				n_res = 2'd1;
				res0  = mk(CMD_WAKE, '0, '0, BLACK, active_q, active_q & restore_en_q,
					1'b0, 1'b1);
				if (active_q) begin
					active_d     = 1'b0;
					idle_start_d = item.now_ticks;
				end
			end
			REQ_POLL: begin
				if (!active_q) begin
					if (idle_due) begin
						n_res        = 2'd2;
						active_d     = 1'b1;
						icon_x_d     = XW'(START_POS);
						icon_y_d     = YW'(START_POS);
						step_x_neg_d = 1'b0;
						step_y_neg_d = 1'b0;
						last_frame_d = item.now_ticks;
						res0 = mk(CMD_CLEAR, '0, '0, BLACK, 1'b0, 1'b0, 1'b1, 1'b0);
						res1 = mk(CMD_DRAW, CALC_W'(START_POS), CALC_W'(START_POS), WHITE,
							1'b0, 1'b0, 1'b1, 1'b1);
					end
				end else if (frame_due) begin
					n_res        = 2'd2;
					last_frame_d = item.now_ticks;
					icon_x_d     = XW'(ax.pos);
					icon_y_d     = YW'(ay.pos);
					step_x_neg_d = ax.neg;
					step_y_neg_d = ay.neg;
					res0 = mk(CMD_ERASE, cur_x, cur_y, BLACK, 1'b0, 1'b0, 1'b1, 1'b0);
					res1 = mk(CMD_DRAW, ax.pos, ay.pos, color_q, 1'b0, 1'b0, 1'b1, 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= 32'hFFFF_FFFF;
			frame_q      <= 32'd0;
			color_q      <= WHITE;
			restore_en_q <= 1'b0;
			active_q     <= 1'b0;
			idle_start_q <= '0;
			last_frame_q <= '0;
			icon_x_q     <= XW'(START_POS);
			icon_y_q     <= YW'(START_POS);
			step_x_neg_q <= 1'b0;
			step_y_neg_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_IDLE_TIMEOUT: timeout_q    <= cfg_data;
					CFG_FRAME_PERIOD: frame_q      <= cfg_data;
					CFG_ICON_COLOR:   color_q      <= cfg_data[COLOR_W-1:0];
					CFG_RESTORE_EN:   restore_en_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (fire) begin
				active_q     <= active_d;
				idle_start_q <= idle_start_d;
				last_frame_q <= last_frame_d;
				icon_x_q     <= icon_x_d;
				icon_y_q     <= icon_y_d;
				step_x_neg_q <= step_x_neg_d;
				step_y_neg_q <= step_y_neg_d;
			end
		end
	end

endmodule

/* tb/tb.sv */
import isb_pkg::*;

// Tracks the saver state and queues the command transactions each request should cause.
class bounce_scoreboard;
	logic [31:0]  idle_limit;
	logic [31:0]  frame_ticks;
	logic [15:0]  icon_rgb;
	logic         restore_en;

	logic         saver_on;
	logic [63:0]  idle_t0;
	logic [63:0]  frame_t0;
	isb_axis_t    ax;
	isb_axis_t    ay;

	isb_result_t  cmd_due[$];
	int           mismatches;
	int           checked;

	function new();
		idle_limit    = 32'hFFFF_FFFF;
		frame_ticks   = 32'd0;
		icon_rgb      = WHITE;
		restore_en    = 1'b0;
		saver_on      = 1'b0;
		idle_t0       = 64'd0;
		frame_t0      = 64'd0;
		ax.pos        = 16'(START_POS);
		ax.neg        = 1'b0;
		ay            = ax;
		mismatches    = 0;
		checked       = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
		case (idx)
			CFG_IDLE_TIMEOUT: idle_limit = v;
			CFG_FRAME_PERIOD: frame_ticks = v;
			CFG_ICON_COLOR: icon_rgb = v[15:0];
			CFG_RESTORE_EN: restore_en = v[0];
			default: ;
		endcase
	endfunction

	function int pending();
		return cmd_due.size();
	endfunction

	function void push(logic [CMD_W-1:0] cmd, isb_axis_t px, isb_axis_t py,
			logic [15:0] rgb, logic wk, logic rr, logic fin);
		isb_result_t r;
		r.command         = cmd;
		r.pos_x           = px.pos[POS_X_W-1:0];
		r.pos_y           = py.pos[POS_Y_W-1:0];
		r.draw_color      = rgb;
		r.woke            = wk;
		r.restore_request = rr;
		r.saver_active    = saver_on;
		r.last            = fin;
		cmd_due.push_back(r);
	endfunction

	// step, and on edge contact flip direction and step once more
	function isb_axis_t bump(isb_axis_t a, int limit);
		int p;
		p = a.pos;
		p += a.neg ? -2 : 2;
		if (p <= 0 || p + ICON_EDGE_DEF >= limit) begin
			a.neg = !a.neg;
			p += a.neg ? -2 : 2;
		end
		a.pos = 16'(p);
		return a;
	endfunction

	function void note_request(logic [REQ_W-1:0] req, logic [TICK_W-1:0] now);
		isb_axis_t zero;
		logic      wk;
		zero.pos = '0;
		zero.neg = 1'b0;
		case (req)
			REQ_ACTIVITY: begin
				saver_on = 1'b0;
				idle_t0  = now;
			end
			REQ_WAKE: begin
				wk = saver_on;
				if (saver_on) begin
					saver_on = 1'b0;
					idle_t0  = now;
				end
				push(CMD_WAKE, zero, zero, BLACK, wk, wk & restore_en, 1'b1);
			end
			REQ_POLL: begin
				if (!saver_on) begin
					if (now - idle_t0 >= {32'd0, idle_limit}) begin
						saver_on = 1'b1;
						ax.pos   = 16'(START_POS);
						ax.neg   = 1'b0;
						ay       = ax;
						frame_t0 = now;
						push(CMD_CLEAR, zero, zero, BLACK, 1'b0, 1'b0, 1'b0);
						push(CMD_DRAW, ax, ay, WHITE, 1'b0, 1'b0, 1'b1);
					end
				end else if (now - frame_t0 >= {32'd0, frame_ticks}) begin
					frame_t0 = now;
					push(CMD_ERASE, ax, ay, BLACK, 1'b0, 1'b0, 1'b0);
					ax = bump(ax, SCREEN_WIDTH_DEF);
					ay = bump(ay, SCREEN_HEIGHT_DEF);
					push(CMD_DRAW, ax, ay, icon_rgb, 1'b0, 1'b0, 1'b1);
				end
			end
			default: ;
		endcase
	endfunction

	function void check_command(isb_result_t got);
		isb_result_t want;
		checked++;
		if (cmd_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected command transaction: cmd=%0d x=%0d y=%0d color=%h",
					got.command, got.pos_x, got.pos_y, got.draw_color);
			return;
		end
		want = cmd_due.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("mismatch: want cmd=%0d x=%0d y=%0d color=%h woke=%b rr=%b act=%b last=%b",
					want.command, want.pos_x, want.pos_y, want.draw_color, want.woke,
					want.restore_request, want.saver_active, want.last);
				$display("          got  cmd=%0d x=%0d y=%0d color=%h woke=%b rr=%b act=%b last=%b",
					got.command, got.pos_x, got.pos_y, got.draw_color, got.woke,
					got.restore_request, got.saver_active, got.last);
			end
		end
	endfunction
endclass

module tb;
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	isb_in_if  in_ch();
	isb_out_if out_ch();

	idle_screensaver_bounce u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	bounce_scoreboard sb = new();

	int          send_idle_pct;
	int          recv_idle_pct;
	int          sent;
	logic [63:0] tick_cursor;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	task automatic set_idle_mode(input int snd, input int rcv);
		send_idle_pct = snd;
		recv_idle_pct = rcv;
	endtask

	task automatic send_req(input logic [REQ_W-1:0] req, input logic [TICK_W-1:0] now);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.req_type  <= req;
		in_ch.now_ticks <= now;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_request(req, now);
		sent++;
	endtask

	// lets the block drain; trailing cycles cover items that emit nothing
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic cfg_poke(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic write_config(input logic [31:0] timeout, input logic [31:0] period,
			input logic [15:0] rgb, input logic rest);
		cfg_poke(CFG_IDLE_TIMEOUT, timeout);
		cfg_poke(CFG_FRAME_PERIOD, period);
		cfg_poke(CFG_ICON_COLOR, {16'd0, rgb});
		cfg_poke(CFG_RESTORE_EN, {31'd0, rest});
		cfg_we <= 1'b0;
	endtask

	// mostly monotonic time with random steps, some raw random timestamps mixed in
	task automatic run_random(input int n, input logic [31:0] span);
		int               pick;
		logic [REQ_W-1:0] req;
		logic [63:0]      now;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 80)
				req = REQ_POLL;
			else if (pick < 88)
				req = REQ_ACTIVITY;
			else if (pick < 95)
				req = REQ_WAKE;
			else
				req = REQ_UNUSED;
			if ($urandom_range(99) < 15) begin
				now = {$urandom, $urandom};
			end else begin
				tick_cursor += {32'd0, $urandom_range(span, 0)};
				now = tick_cursor;
			end
			send_req(req, now);
		end
	endtask

	initial begin : result_sink
		int          hold_left;
		bit          held;
		isb_result_t got;
		hold_left = 0;
		held      = 1'b0;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				got.command         = out_ch.command;
				got.pos_x           = out_ch.pos_x;
				got.pos_y           = out_ch.pos_y;
				got.draw_color      = out_ch.draw_color;
				got.woke            = out_ch.woke;
				got.restore_request = out_ch.restore_request;
				got.saver_active    = out_ch.saver_active;
				got.last            = out_ch.last;
				sb.check_command(got);
			end
			// one long back-pressure stretch while the sender keeps pushing frames
			if (hold_left > 0)
				hold_left--;
			else if (!held && sb.checked >= 40) begin
				held      = 1'b1;
				hold_left = 300;
			end
			out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : stimulus
		arst_n          <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= CFG_IDLE_TIMEOUT;
		cfg_data        <= '0;
		in_ch.valid     <= 1'b0;
		in_ch.req_type  <= REQ_POLL;
		in_ch.now_ticks <= '0;
		sent            = 0;
		tick_cursor     = 64'd0;
		set_idle_mode(32, 50);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: timeout at max, frames every poll
		send_req(REQ_POLL, 64'd0);
		send_req(REQ_WAKE, 64'd5);
		send_req(REQ_POLL, 64'hFFFF_FFFE);
		send_req(REQ_POLL, 64'hFFFF_FFFF);
		send_req(REQ_POLL, 64'hFFFF_FFFF);
		send_req(REQ_UNUSED, '1);
		send_req(REQ_WAKE, '1);
		// elapsed time wraps past zero
		send_req(REQ_POLL, 64'hFFFF_FFFD);
		send_req(REQ_POLL, 64'hFFFF_FFFE);
		send_req(REQ_ACTIVITY, 64'h8000_0000_0000_0000);
		send_req(REQ_POLL, 64'h8000_0000_0000_0001);
		send_req(REQ_WAKE, 64'h8000_0000_0000_0002);
		settle();

		write_config(32'd0, 32'd3, 16'h1234, 1'b1);
		send_req(REQ_POLL, 64'd10);
		send_req(REQ_POLL, 64'd12);
		send_req(REQ_POLL, 64'd13);
		send_req(REQ_WAKE, 64'd20);
		send_req(REQ_WAKE, 64'd21);
		settle();

		// long uninterrupted animation to reach the right and bottom edges
		write_config(32'd0, 32'd0, 16'h0000, 1'b0);
		for (int i = 0; i < 320; i++)
			send_req(REQ_POLL, {$urandom, $urandom});
		settle();

		set_idle_mode(50, 32);
		write_config($urandom_range(200, 20), $urandom_range(20, 2), 16'($urandom), 1'b1);
		run_random(120, 32'd40);
		settle();

		set_idle_mode(0, 0);
		write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
		run_random(100, 32'hFFFF_FFFF);
		settle();

		write_config(32'd1, 32'd1, 16'($urandom), 1'b1);
		run_random(100, 32'd3);
		settle();

		$display("covered %0d requests, %0d command transactions checked over six settings",
			sent, sb.checked);
		$display("idle timeouts, wrapped time, wakes with and without restore, edge bounces");
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule
